// ===== src/histogram_trimmed_level_bounds_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the level-bounds block
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_TRIMMED_LEVEL_BOUNDS_MACROS_SVH
`define HISTOGRAM_TRIMMED_LEVEL_BOUNDS_MACROS_SVH

// Concurrent check on the rising clock, off while the active-low reset is low
`define HTLB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("htlb assertion failed");

// Shorthand for the block's own clock and reset names
`define HTLB_ASSERT_CLK(label, prop) \
  `HTLB_ASSERT(label, clk_i, rst_ni, prop)

`endif

// ===== src/htlb_pkg.sv =====
// ----------------------------------------------------------------------------
// htlb_pkg
// Constants, types and state codes of the level-bounds block.
// ----------------------------------------------------------------------------
`default_nettype none

package htlb_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned NUM_BINS   = 1 << BIN_W;
  localparam int unsigned TRIM_NUM   = 39;
  localparam int unsigned TRIM_DEN   = 10000;
  // count * TRIM_NUM needs 6 extra bits (TRIM_NUM < 64)
  localparam int unsigned PROD_W     = COUNT_BITS + 6;

  // floor(x / TRIM_DEN) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 2^PROD_W
  localparam int unsigned RECIP_SHIFT = PROD_W + $clog2(TRIM_DEN);
  localparam int unsigned RECIP_W     = PROD_W + 1;
  localparam longint unsigned RECIP_RAW =
    ((64'd1 << RECIP_SHIFT) + 64'(TRIM_DEN) - 64'd1) / 64'(TRIM_DEN);
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_RAW);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_W-1:0]      bin_t;

  localparam count_t COUNT_MAX = '1;
  localparam bin_t   BIN_MAX   = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_MUL,
    ST_DIV,
    ST_SPLIT,
    ST_TOP_RD,
    ST_TOP_WR,
    ST_BOT_RD,
    ST_BOT_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== src/htlb_sample_if.sv =====
// ----------------------------------------------------------------------------
// htlb_sample_if
// Input channel: one intensity sample per item, last flag marks image end.
// ----------------------------------------------------------------------------
`default_nettype none

interface htlb_sample_if;
  import htlb_pkg::*;

  logic valid;
  logic ready;
  bin_t sample;
  logic last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

// ===== src/htlb_bounds_if.sv =====
// ----------------------------------------------------------------------------
// htlb_bounds_if
// Output channel: darkest and brightest occupied bins of one image.
// ----------------------------------------------------------------------------
`default_nettype none

interface htlb_bounds_if;
  import htlb_pkg::*;

  logic valid;
  logic ready;
  bin_t darkest;
  bin_t brightest;

  modport source (output valid, output darkest, output brightest, input ready);
  modport sink   (input valid, input darkest, input brightest, output ready);
endinterface

`default_nettype wire

// ===== src/htlb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// htlb_cfg_if
// Configuration write channel for the trim enable register.
// ----------------------------------------------------------------------------
`default_nettype none

interface htlb_cfg_if;
  logic valid;
  logic ready;
  logic trim_enable;

  modport source (output valid, output trim_enable, input ready);
  modport sink   (input valid, input trim_enable, output ready);
endinterface

`default_nettype wire

// ===== src/histogram_trimmed_level_bounds.sv =====
// ----------------------------------------------------------------------------
// histogram_trimmed_level_bounds
// Auto-levels bound finder: histogram of 8-bit samples, optional clipping of
// about 0.39 % extreme samples, then darkest/brightest occupied bins.
// ----------------------------------------------------------------------------
//
//  channel       dir  handshake     payload
//  ------------  ---  ------------  ---------------------------------------
//  sample_ch_i   in   valid/ready   sample[7:0], last_sample
//  bounds_ch_o   out  valid/ready   darkest[7:0], brightest[7:0]
//  cfg_ch_i      in   valid/ready   trim_enable (always ready)
//
//  A non-last sample takes a bin read, then a bin write (+1, saturating).
//  A last sample adds, with trimming on, the trim count (shared multiplier:
//  by 39, then by the reciprocal of 10000; then halves) and a bin read and
//  write per bin visited by each trim walk (top, bottom); then the bound
//  scan, a read and a check per bin, and the hand-over.
//  Histogram RAM has one read and one write port; bins are cleared at once
//  through per-bin valid bits, so no clearing pass follows reset.
//  A result waits in the output register; new samples are taken meanwhile,
//  only the hand-over of the next result stalls on a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_trimmed_level_bounds (
  input  wire            clk_i,
  input  wire            rst_ni,
  htlb_sample_if.sink    sample_ch_i,
  htlb_bounds_if.source  bounds_ch_o,
  htlb_cfg_if.sink       cfg_ch_i
);
  import htlb_pkg::*;

  `include "histogram_trimmed_level_bounds_macros.svh"

  // --- control state --------------------------------------------------------
  state_e                state_q, state_d;
  bin_t                  addr_q, addr_d;      // bin pointer shared by all walks
  logic                  last_q, last_d;
  count_t                count_q, count_d;    // saturating sample counter
  count_t                n_q, n_d;            // samples still to drop
  logic [PROD_W-1:0]     div_q, div_d;        // product, then trim count
  logic                  found_q, found_d;
  bin_t                  dark_q, dark_d;
  bin_t                  bright_q, bright_d;
  logic                  trim_en_q;
  logic                  out_valid_q, out_valid_d;
  bin_t                  out_dark_q, out_dark_d;
  bin_t                  out_bright_q, out_bright_d;

  // --- histogram store --------------------------------------------------------
  count_t                hist_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_vld_q;
  count_t                rdata_q;
  logic                  rvld_q;
  bin_t                  rd_addr;
  logic                  mem_we;
  count_t                wdata;
  logic                  clr_all;

  // --- shared datapath --------------------------------------------------------
  count_t                bin_val;
  count_t                take;
  logic [PROD_W-1:0]     mul_a;
  logic [RECIP_W-1:0]    mul_b;
  logic [PROD_W+RECIP_W-1:0] mul_p;
  logic                  in_acc;

  assign in_acc  = sample_ch_i.valid && sample_ch_i.ready;
  assign bin_val = rvld_q ? rdata_q : '0;
  assign take    = (bin_val < n_q) ? bin_val : n_q;

  // one multiplier: count by 39, then product by the reciprocal of 10000
  assign mul_p   = {{RECIP_W{1'b0}}, mul_a} * {{PROD_W{1'b0}}, mul_b};

  // RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[addr_q] <= wdata;
    end
    rdata_q <= hist_mem[rd_addr];
  end

  // per-bin valid bits: an unwritten bin reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      rvld_q <= bin_vld_q[rd_addr];
      if (clr_all) begin
        bin_vld_q <= '0;
      end else if (mem_we) begin
        bin_vld_q[addr_q] <= 1'b1;
      end
    end
  end

  // config register
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_en_q <= 1'b0;
    end else if (cfg_ch_i.valid) begin
      trim_en_q <= cfg_ch_i.trim_enable;
    end
  end

  // --- sequencer --------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      last_q       <= 1'b0;
      count_q      <= '0;
      n_q          <= '0;
      div_q        <= '0;
      found_q      <= 1'b0;
      dark_q       <= '0;
      bright_q     <= BIN_MAX;
      out_valid_q  <= 1'b0;
      out_dark_q   <= '0;
      out_bright_q <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      last_q       <= last_d;
      count_q      <= count_d;
      n_q          <= n_d;
      div_q        <= div_d;
      found_q      <= found_d;
      dark_q       <= dark_d;
      bright_q     <= bright_d;
      out_valid_q  <= out_valid_d;
      out_dark_q   <= out_dark_d;
      out_bright_q <= out_bright_d;
    end
  end

  assign sample_ch_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    last_d       = last_q;
    count_d      = count_q;
    n_d          = n_q;
    div_d        = div_q;
    found_d      = found_q;
    dark_d       = dark_q;
    bright_d     = bright_q;
    out_valid_d  = out_valid_q && !bounds_ch_o.ready;
    out_dark_d   = out_dark_q;
    out_bright_d = out_bright_q;
    rd_addr      = addr_q;
    mem_we       = 1'b0;
    wdata        = bin_val;
    clr_all      = 1'b0;
    mul_a        = div_q;
    mul_b        = RECIP_MUL;

    case (state_q)
      ST_IDLE: begin
        rd_addr  = sample_ch_i.sample;
        found_d  = 1'b0;
        dark_d   = '0;
        bright_d = BIN_MAX;
        if (in_acc) begin
          addr_d  = sample_ch_i.sample;
          last_d  = sample_ch_i.last_sample;
          count_d = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
          state_d = ST_INC;
        end
      end

      ST_INC: begin
        mem_we = 1'b1;
        wdata  = (bin_val == COUNT_MAX) ? bin_val : bin_val + 1'b1;
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (trim_en_q) begin
          state_d = ST_MUL;
        end else begin
          addr_d  = '0;
          state_d = ST_SCAN_RD;
        end
      end

      ST_MUL: begin
        mul_a   = PROD_W'(count_q);
        mul_b   = RECIP_W'(TRIM_NUM);
        div_d   = PROD_W'(mul_p);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        // product times reciprocal, top bits give the exact quotient
        div_d   = PROD_W'(mul_p >> RECIP_SHIFT);
        state_d = ST_SPLIT;
      end

      ST_SPLIT: begin
        // bright end gives up the ceiling of half
        n_d     = COUNT_BITS'(div_q - (div_q >> 1));
        addr_d  = BIN_MAX;
        state_d = ST_TOP_RD;
      end

      ST_TOP_RD: begin
        if (n_q == '0) begin
          n_d     = COUNT_BITS'(div_q >> 1);
          addr_d  = '0;
          state_d = ST_BOT_RD;
        end else begin
          state_d = ST_TOP_WR;
        end
      end

      ST_TOP_WR: begin
        mem_we = 1'b1;
        wdata  = bin_val - take;
        n_d    = n_q - take;
        if (n_d == '0 || addr_q == '0) begin
          n_d     = COUNT_BITS'(div_q >> 1);
          addr_d  = '0;
          state_d = ST_BOT_RD;
        end else begin
          addr_d  = addr_q - 1'b1;
          state_d = ST_TOP_RD;
        end
      end

      ST_BOT_RD: begin
        if (n_q == '0) begin
          addr_d  = '0;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_BOT_WR;
        end
      end

      ST_BOT_WR: begin
        mem_we = 1'b1;
        wdata  = bin_val - take;
        n_d    = n_q - take;
        if (n_d == '0 || addr_q == BIN_MAX) begin
          addr_d  = '0;
          state_d = ST_SCAN_RD;
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = ST_BOT_RD;
        end
      end

      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (bin_val != '0) begin
          if (!found_q) begin
            dark_d  = addr_q;
            found_d = 1'b1;
          end
          bright_d = addr_q;
        end
        if (addr_q == BIN_MAX) begin
          state_d = ST_DONE;
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || bounds_ch_o.ready) begin
          out_valid_d  = 1'b1;
          out_dark_d   = dark_q;
          out_bright_d = bright_q;
          clr_all      = 1'b1;
          count_d      = '0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign bounds_ch_o.valid     = out_valid_q;
  assign bounds_ch_o.darkest   = out_dark_q;
  assign bounds_ch_o.brightest = out_bright_q;

  // --- checks -------------------------------------------------------------------
  `HTLB_ASSERT_CLK(a_plain_sample_two_cycles,
    (in_acc && !sample_ch_i.last_sample) |=> (state_q == ST_INC) ##1 (state_q == ST_IDLE))
  `HTLB_ASSERT_CLK(a_result_only_from_done,
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `HTLB_ASSERT_CLK(a_counter_cleared_with_result,
    $rose(out_valid_q) |-> (count_q == '0 && bin_vld_q == '0))
  `HTLB_ASSERT_CLK(a_trim_never_grows,
    (state_q == ST_TOP_WR || state_q == ST_BOT_WR) |-> (take <= n_q && take <= bin_val))

endmodule

`default_nettype wire
